### src/hdbn_pkg.sv
// Shared types and constants for the HDBn line encoder.
`default_nettype none

package hdbn_pkg;

  typedef logic signed [1:0] sym_t;

  localparam sym_t SymSpace = 2'sb00;
  localparam sym_t SymPos   = 2'sb01;
  localparam sym_t SymNeg   = 2'sb11;

  localparam logic [3:0] LimitReset = 4'd3;

  // coded form of one input bit
  typedef struct packed {
    sym_t cur;    // symbol for the current position
    logic subst;  // substitution ends here
    sym_t bal;    // symbol for the position n back
  } code_t;

  // window status seen by the input side
  typedef struct packed {
    logic busy;       // symbols still owed from an earlier transfer
    logic slot_free;  // output register free or being taken
  } win_status_t;

endpackage

`default_nettype wire

### src/hdbn_polarity.sv
// Mark/violation polarity tracking and zero run detection.
`default_nettype none

module hdbn_polarity
  import hdbn_pkg::*;
#(
  parameter int unsigned MAX_RUN = 8,
  localparam int unsigned CW = $clog2(MAX_RUN + 2)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          data_bit_i,
  input  wire logic          last_bit_i,
  input  wire logic [CW-1:0] limit_i,
  output code_t              code_o
);

  logic [CW-1:0] zero_run_q, zero_run_d, run_inc;
  logic          pulse_pos_q, pulse_pos_d;
  logic          viol_pos_q, viol_pos_d;

  always_comb begin
    run_inc     = zero_run_q + CW'(1);
    code_o      = '{cur: SymSpace, subst: 1'b0, bal: SymSpace};
    zero_run_d  = zero_run_q;
    pulse_pos_d = pulse_pos_q;
    viol_pos_d  = viol_pos_q;
    if (data_bit_i) begin
      code_o.cur  = pulse_pos_q ? SymNeg : SymPos;
      pulse_pos_d = !pulse_pos_q;
      zero_run_d  = '0;
    end else if (run_inc <= limit_i) begin
      zero_run_d = run_inc;
    end else begin
      code_o.subst = 1'b1;
      zero_run_d   = '0;
      if (viol_pos_q) begin
        code_o.bal  = pulse_pos_q ? SymNeg : SymSpace;
        code_o.cur  = SymNeg;
        pulse_pos_d = 1'b0;
        viol_pos_d  = 1'b0;
      end else begin
        code_o.bal  = pulse_pos_q ? SymSpace : SymPos;
        code_o.cur  = SymPos;
        pulse_pos_d = 1'b1;
        viol_pos_d  = 1'b1;
      end
    end
    if (last_bit_i) begin
      zero_run_d  = '0;
      pulse_pos_d = 1'b0;
      viol_pos_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q  <= '0;
      pulse_pos_q <= 1'b0;
      viol_pos_q  <= 1'b0;
    end else if (accept_i) begin
      zero_run_q  <= zero_run_d;
      pulse_pos_q <= pulse_pos_d;
      viol_pos_q  <= viol_pos_d;
    end
  end

endmodule

`default_nettype wire

### src/hdbn_window.sv
// Symbol window with substitution rewrite, drain control and output register.
`default_nettype none

module hdbn_window
  import hdbn_pkg::*;
#(
  parameter int unsigned MAX_RUN = 8,
  localparam int unsigned CW = $clog2(MAX_RUN + 2),
  localparam int unsigned DEPTH = MAX_RUN + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic          last_bit_i,
  input  wire code_t         code_i,
  input  wire logic [CW-1:0] limit_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output sym_t               symbol_o,
  output logic               end_of_block_o,
  output win_status_t        status_o
);

  sym_t          win_q [DEPTH];
  sym_t          win_d [DEPTH];
  sym_t          merged [DEPTH];
  logic [CW-1:0] fill_q, fill_d, mfill;
  logic [CW-1:0] drain_q, mdrain;
  logic          flush_q, flush_d, mflush;
  logic          out_valid_q, out_valid_d;
  sym_t          sym_q, sym_d;
  logic          eob_q, eob_d;
  logic          slot_free, pop;
  logic [CW:0]   pos_sum, fill_ext;

  assign slot_free = !out_valid_q || out_ready_i;
  assign status_o  = '{busy: flush_q || (fill_q > drain_q), slot_free: slot_free};

  always_comb begin
    fill_ext = {1'b0, fill_q};
    pos_sum  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      merged[k] = win_q[k];
    end
    mfill  = fill_q;
    mflush = flush_q;
    mdrain = drain_q;
    if (accept_i) begin
      for (int k = 0; k < DEPTH; k++) begin
        pos_sum = (CW + 1)'(k) + {1'b0, limit_i};
        if ((CW + 1)'(k) == fill_ext) begin
          merged[k] = code_i.cur;
        end else if (code_i.subst && (pos_sum == fill_ext)) begin
          merged[k] = code_i.bal;
        end else if (code_i.subst && (pos_sum > fill_ext) && ((CW + 1)'(k) < fill_ext)) begin
          merged[k] = SymSpace;
        end
      end
      mfill  = fill_q + CW'(1);
      mflush = last_bit_i;
      mdrain = limit_i;
    end

    pop = slot_free && (mflush ? (mfill != '0) : (mfill > mdrain));

    for (int k = 0; k < DEPTH; k++) begin
      win_d[k] = merged[k];
    end
    fill_d      = mfill;
    flush_d     = mflush;
    sym_d       = sym_q;
    eob_d       = eob_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (pop) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        win_d[k] = merged[k + 1];
      end
      win_d[DEPTH - 1] = SymSpace;
      fill_d      = mfill - CW'(1);
      flush_d     = mflush && (mfill != CW'(1));
      sym_d       = merged[0];
      eob_d       = mflush && (mfill == CW'(1));
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      drain_q     <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      drain_q     <= mdrain;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        win_q[k] <= SymSpace;
      end
    end else begin
      for (int k = 0; k < DEPTH; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    eob_q <= eob_d;
  end

  assign out_valid_o    = out_valid_q;
  assign symbol_o       = sym_q;
  assign end_of_block_o = eob_q;

endmodule

`default_nettype wire

### src/hdbn_line_encoder.sv
// HDBn line encoder top level: limit register, polarity logic and symbol window.
// Output timing: a symbol released by an input transfer is presented in the cycle after it.
// Throughput: one input bit per cycle in steady state while the output is not stalled; a flush
//   of the held symbols blocks input while the window drains through the output register.
// Reset: asynchronous, active low; window spaces, counters zero, limit 3.
`default_nettype none

module hdbn_line_encoder
  import hdbn_pkg::*;
#(
  parameter int unsigned MAX_RUN = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       data_bit_i,
  input  wire logic       last_bit_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output sym_t            symbol_o,
  output logic            end_of_block_o
);

  localparam int unsigned CW = $clog2(MAX_RUN + 2);
  localparam int unsigned LW = (CW > 4) ? CW : 4;

  logic [3:0]    zero_limit_q;
  logic [LW-1:0] lim_w;
  logic [CW-1:0] limit;
  logic          accept;
  code_t         code;
  win_status_t   status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      zero_limit_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    lim_w = LW'(zero_limit_q);
    if (lim_w == '0) begin
      limit = CW'(1);
    end else if (lim_w > LW'(MAX_RUN)) begin
      limit = CW'(MAX_RUN);
    end else begin
      limit = CW'(lim_w);
    end
  end

  assign in_ready_o = !status.busy && status.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  hdbn_polarity #(
    .MAX_RUN(MAX_RUN)
  ) u_polarity (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .data_bit_i(data_bit_i),
    .last_bit_i(last_bit_i),
    .limit_i   (limit),
    .code_o    (code)
  );

  hdbn_window #(
    .MAX_RUN(MAX_RUN)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .last_bit_i    (last_bit_i),
    .code_i        (code),
    .limit_i       (limit),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .symbol_o      (symbol_o),
    .end_of_block_o(end_of_block_o),
    .status_o      (status)
  );

  a_ready_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input ready while output register is blocked");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_bit_i) |=> out_valid_o)
    else $error("last transfer produced no symbol");

  a_eob_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && end_of_block_o) |=> !status.busy)
    else $error("input still blocked after end of block");

  a_symbol_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (symbol_o != 2'sb10))
    else $error("illegal line symbol");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the HDBn line encoder: directed and random bit streams.
`timescale 1ns / 100ps

module tb_top;
  import hdbn_pkg::*;

  localparam int MaxRun = 8;
  localparam int CycleLimit = 200000;

  class hdbn_scoreboard;
    sym_t        win[MaxRun+1];
    int unsigned fill;
    int unsigned zrun;
    bit          pos_pulse;
    bit          pos_viol;
    logic [3:0]  limit;
    sym_t        exp_sym[$];
    bit          exp_eob[$];
    int          errors;

    function new();
      limit = LimitReset;
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int k = 0; k <= MaxRun; k++) win[k] = SymSpace;
      fill = 0;
      zrun = 0;
      pos_pulse = 1'b0;
      pos_viol = 1'b0;
    endfunction

    function void set_limit(logic [3:0] v);
      limit = v;
    endfunction

    function int unsigned eff_limit();
      int unsigned n;
      n = limit;
      if (n < 1) n = 1;
      if (n > MaxRun) n = MaxRun;
      return n;
    endfunction

    function int pending();
      return exp_sym.size();
    endfunction

    // code one accepted bit and queue the symbols it releases
    function void note_bit(bit d, bit l);
      int unsigned n;
      sym_t cur;
      sym_t bal;
      n = eff_limit();
      if (d) begin
        zrun = 0;
        cur = pos_pulse ? SymNeg : SymPos;
        pos_pulse = !pos_pulse;
      end else begin
        zrun++;
        if (zrun <= n) begin
          cur = SymSpace;
        end else begin
          if (pos_viol) begin
            bal = pos_pulse ? SymNeg : SymSpace;
            cur = SymNeg;
            pos_pulse = 1'b0;
            pos_viol = 1'b0;
          end else begin
            bal = pos_pulse ? SymSpace : SymPos;
            cur = SymPos;
            pos_pulse = 1'b1;
            pos_viol = 1'b1;
          end
          if (fill >= n) begin
            win[fill - n] = bal;
            for (int j = 1; j < n; j++) win[fill - j] = SymSpace;
          end
          zrun = 0;
        end
      end
      if (fill < MaxRun + 1) begin
        win[fill] = cur;
        fill++;
      end
      if (l) begin
        for (int k = 0; k < fill; k++) begin
          exp_sym.push_back(win[k]);
          exp_eob.push_back(k + 1 == fill);
        end
        clear();
      end else begin
        while (fill > n) begin
          exp_sym.push_back(win[0]);
          exp_eob.push_back(1'b0);
          for (int k = 1; k < fill; k++) win[k-1] = win[k];
          fill--;
          win[fill] = SymSpace;
        end
      end
    endfunction

    function void check_symbol(sym_t s, logic e);
      sym_t es;
      bit   ee;
      if (exp_sym.size() == 0) begin
        $error("symbol transfer with nothing expected: symbol %0d end_of_block %b", s, e);
        errors++;
      end else begin
        es = exp_sym.pop_front();
        ee = exp_eob.pop_front();
        if (s !== es) begin
          $error("symbol: expected %0d, actual %0d", es, s);
          errors++;
        end
        if (e !== ee) begin
          $error("end_of_block: expected %b, actual %b", ee, e);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       data_bit_i = 1'b0;
  logic       last_bit_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  sym_t       symbol_o;
  logic       end_of_block_o;

  bit             idle_on = 1'b1;
  int             cycles = 0;
  hdbn_scoreboard sb;

  hdbn_line_encoder #(.MAX_RUN(MaxRun)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_bit_i     (data_bit_i),
    .last_bit_i     (last_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .symbol_o       (symbol_o),
    .end_of_block_o (end_of_block_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.set_limit(cfg_wdata_i);
      if (in_valid_i && in_ready_o) sb.note_bit(data_bit_i, last_bit_i);
      if (out_valid_o && out_ready_i) sb.check_symbol(symbol_o, end_of_block_o);
    end
  end

  task automatic send_bit(bit d, bit l);
    while (idle_on && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_bit_i <= d;
    last_bit_i <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drain all owed symbols, then allow the window logic to settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [3:0] v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= 4'($urandom_range(0, 15));
    @(posedge clk_i);
  endtask

  // mostly zero runs around the limit broken by ones, some noise bits
  task automatic random_bits(int count, bit end_last);
    int n;
    int run;
    int i;
    bit l;
    n = sb.eff_limit();
    i = 0;
    while (i < count) begin
      if ($urandom_range(0, 9) < 7) begin
        run = $urandom_range(0, 2 * n + 3);
        for (int k = 0; k < run && i < count; k++) begin
          l = (end_last && i == count - 1) || ($urandom_range(0, 39) == 0);
          send_bit(1'b0, l);
          i++;
        end
        if (i < count) begin
          l = (end_last && i == count - 1) || ($urandom_range(0, 39) == 0);
          send_bit(1'b1, l);
          i++;
        end
      end else begin
        l = (end_last && i == count - 1) || ($urandom_range(0, 29) == 0);
        send_bit(1'($urandom_range(0, 1)), l);
        i++;
      end
    end
  endtask

  initial begin
    logic [3:0] phase_limit[8];
    phase_limit = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd9, 4'd3};
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset limit: space B on the first substitution, pulse B on the second
    send_bit(1'b1, 1'b0);
    for (int k = 0; k < 8; k++) send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);

    // zero limit acts as one
    write_limit(4'd0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);

    // limit above range acts as the maximum; full window flush
    write_limit(4'd15);
    for (int k = 0; k < 8; k++) send_bit(1'b0, 1'b0);
    send_bit(1'b0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_limit(p < 7 ? phase_limit[p] : 4'($urandom_range(0, 15)));
      idle_on = (p != 3);
      random_bits(50, (p == 7) || ($urandom_range(0, 1) == 1));
    end
    idle_on = 1'b1;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
